### rtl/miller_rabin_prime_test_core_defines.svh
// Assertion macros used by the prime test core controller.
`ifndef MILLER_RABIN_PRIME_TEST_CORE_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, quiet while reset is held.
`define MRPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define MRPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MRPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/mrpt_pkg.sv
// Shared constants, command/status types and witness table for the prime test core.
`default_nettype none

package mrpt_pkg;

    localparam int DEFAULT_WIDTH = 64;
    localparam int NUM_WIT       = 12;
    localparam int WIT_IDX_W     = 4;
    localparam int WIT_VAL_W     = 6;

    typedef logic [1:0] t_mul_op;

    localparam t_mul_op MUL_X_BASE    = 2'd0;
    localparam t_mul_op MUL_BASE_BASE = 2'd1;
    localparam t_mul_op MUL_X_X       = 2'd2;

    typedef struct packed {
        logic    load;
        logic    split_init;
        logic    split_shift;
        logic    wit_first;
        logic    wit_next;
        logic    pow_init;
        logic    e_shift;
        logic    mul_start;
        t_mul_op mul_op;
        logic    r_clear;
        logic    r_inc;
    } t_cmd;

    typedef struct packed {
        logic n_two;
        logic n_small_or_even;
        logic d_odd;
        logic w_end;
        logic a_ge_n;
        logic e_zero;
        logic e_one;
        logic e_lsb;
        logic x_is_one;
        logic x_is_nm1;
        logic r_last;
        logic mul_busy;
    } t_stat;

    function automatic logic [WIT_VAL_W-1:0] witness_value(input logic [WIT_IDX_W-1:0] idx);
        logic [WIT_VAL_W-1:0] val;
        case (idx)
            4'd0:    val = 6'd2;
            4'd1:    val = 6'd3;
            4'd2:    val = 6'd5;
            4'd3:    val = 6'd7;
            4'd4:    val = 6'd11;
            4'd5:    val = 6'd13;
            4'd6:    val = 6'd17;
            4'd7:    val = 6'd19;
            4'd8:    val = 6'd23;
            4'd9:    val = 6'd29;
            4'd10:   val = 6'd31;
            4'd11:   val = 6'd37;
            default: val = 6'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### rtl/mrpt_datapath.sv
// Datapath: candidate registers, d/s split, exponent, witness index and bit-serial modmul.
`default_nettype none

module mrpt_datapath #(
    parameter int WIDTH = mrpt_pkg::DEFAULT_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [63:0]   i_candidate,
    input  wire mrpt_pkg::t_cmd i_cmd,
    output mrpt_pkg::t_stat    o_stat
);

    localparam int CNT_W = $clog2(WIDTH);

    // (x + y) mod m with x, y below m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH-1:0] gap;
        gap = m - y;
        return (x < gap) ? (x + y) : (x - gap);
    endfunction

    logic [WIDTH-1:0]               r_n, r_nm1, r_d, r_x, r_base, r_e;
    logic [WIDTH-1:0]               r_acc, r_mx, r_my;
    logic [CNT_W-1:0]               r_s, r_r;
    logic [mrpt_pkg::WIT_IDX_W-1:0] r_w;
    logic                           r_mbusy, r_mdst_base;

    logic [mrpt_pkg::WIT_VAL_W-1:0] wit_val;
    logic [WIDTH-1:0]               wit_ext;
    logic [WIDTH-1:0]               op_a, op_b;
    logic [CNT_W:0]                 r_plus1;

    assign wit_val = mrpt_pkg::witness_value(r_w);
    assign wit_ext = {{(WIDTH - mrpt_pkg::WIT_VAL_W){1'b0}}, wit_val};
    assign r_plus1 = {1'b0, r_r} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        case (i_cmd.mul_op)
            mrpt_pkg::MUL_X_BASE: begin
                op_a = r_x;
                op_b = r_base;
            end
            mrpt_pkg::MUL_BASE_BASE: begin
                op_a = r_base;
                op_b = r_base;
            end
            default: begin
                op_a = r_x;
                op_b = r_x;
            end
        endcase
    end

    // multiplier control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && (r_my == '0)) begin
            r_mbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_candidate[WIDTH-1:0];
        end
        if (i_cmd.split_init) begin
            r_nm1 <= r_n - WIDTH'(1);
            r_d   <= r_n - WIDTH'(1);
            r_s   <= '0;
        end else if (i_cmd.split_shift) begin
            r_d <= r_d >> 1;
            r_s <= r_s + CNT_W'(1);
        end
        if (i_cmd.wit_first) begin
            r_w <= '0;
        end else if (i_cmd.wit_next) begin
            r_w <= r_w + mrpt_pkg::WIT_IDX_W'(1);
        end
        if (i_cmd.r_clear) begin
            r_r <= '0;
        end else if (i_cmd.r_inc) begin
            r_r <= r_r + CNT_W'(1);
        end
        if (i_cmd.pow_init) begin
            r_e <= r_d;
        end else if (i_cmd.e_shift) begin
            r_e <= r_e >> 1;
        end

        // shift-and-add modular multiply, one multiplier bit per cycle
        if (i_cmd.mul_start) begin
            r_acc       <= '0;
            r_mx        <= op_a;
            r_my        <= op_b;
            r_mdst_base <= (i_cmd.mul_op == mrpt_pkg::MUL_BASE_BASE);
        end else if (r_mbusy && (r_my != '0)) begin
            if (r_my[0]) begin
                r_acc <= add_mod(r_acc, r_mx, r_n);
            end
            r_mx <= add_mod(r_mx, r_mx, r_n);
            r_my <= r_my >> 1;
        end

        if (i_cmd.pow_init) begin
            r_x    <= WIDTH'(1);
            r_base <= wit_ext;
        end else if (r_mbusy && (r_my == '0)) begin
            if (r_mdst_base) begin
                r_base <= r_acc;
            end else begin
                r_x <= r_acc;
            end
        end
    end

    always_comb begin
        o_stat.n_two           = (r_n == WIDTH'(2));
        o_stat.n_small_or_even = (r_n[WIDTH-1:1] == '0) || !r_n[0];
        o_stat.d_odd           = r_d[0];
        o_stat.w_end           = (r_w == mrpt_pkg::WIT_IDX_W'(mrpt_pkg::NUM_WIT));
        o_stat.a_ge_n          = (wit_ext >= r_n);
        o_stat.e_zero          = (r_e == '0);
        o_stat.e_one           = (r_e == WIDTH'(1));
        o_stat.e_lsb           = r_e[0];
        o_stat.x_is_one        = (r_x == WIDTH'(1));
        o_stat.x_is_nm1        = (r_x == r_nm1);
        o_stat.r_last          = (r_plus1 == {1'b0, r_s});
        o_stat.mul_busy        = r_mbusy;
    end

endmodule

`default_nettype wire

### rtl/mrpt_ctrl.sv
// Controller: sequences the split, witness loop, exponentiation and squaring chain.
`default_nettype none

`include "miller_rabin_prime_test_core_defines.svh"

module mrpt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire mrpt_pkg::t_stat i_stat,
    output mrpt_pkg::t_cmd       o_cmd,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic                 o_is_prime
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_SPLIT   = 4'd2;
    localparam logic [3:0] S_WSEL    = 4'd3;
    localparam logic [3:0] S_POW     = 4'd4;
    localparam logic [3:0] S_POW_MUL = 4'd5;
    localparam logic [3:0] S_SQB     = 4'd6;
    localparam logic [3:0] S_SQB_MUL = 4'd7;
    localparam logic [3:0] S_TEST    = 4'd8;
    localparam logic [3:0] S_SQ_CHK  = 4'd9;
    localparam logic [3:0] S_SQ_MUL  = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_prime, n_prime;

    always_comb begin
        n_state = r_state;
        n_prime = r_prime;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.n_two) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.n_small_or_even) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.split_init = 1'b1;
                    n_state          = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (i_stat.d_odd) begin
                    o_cmd.wit_first = 1'b1;
                    n_state         = S_WSEL;
                end else begin
                    o_cmd.split_shift = 1'b1;
                end
            end
            S_WSEL: begin
                if (i_stat.w_end) begin
                    n_prime = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.a_ge_n) begin
                    o_cmd.wit_next = 1'b1;
                end else begin
                    o_cmd.pow_init = 1'b1;
                    n_state        = S_POW;
                end
            end
            S_POW: begin
                if (i_stat.e_zero) begin
                    n_state = S_TEST;
                end else if (i_stat.e_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mrpt_pkg::MUL_X_BASE;
                    n_state         = S_POW_MUL;
                end else begin
                    n_state = S_SQB;
                end
            end
            S_POW_MUL: begin
                if (!i_stat.mul_busy) begin
                    n_state = S_SQB;
                end
            end
            S_SQB: begin
                // last exponent bit: the squared base is never used
                o_cmd.e_shift = 1'b1;
                if (i_stat.e_one) begin
                    n_state = S_TEST;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mrpt_pkg::MUL_BASE_BASE;
                    n_state         = S_SQB_MUL;
                end
            end
            S_SQB_MUL: begin
                if (!i_stat.mul_busy) begin
                    n_state = S_POW;
                end
            end
            S_TEST: begin
                if (i_stat.x_is_one) begin
                    o_cmd.wit_next = 1'b1;
                    n_state        = S_WSEL;
                end else begin
                    o_cmd.r_clear = 1'b1;
                    n_state       = S_SQ_CHK;
                end
            end
            S_SQ_CHK: begin
                if (i_stat.x_is_nm1) begin
                    o_cmd.wit_next = 1'b1;
                    n_state        = S_WSEL;
                end else if (i_stat.r_last || i_stat.x_is_one) begin
                    n_prime = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.r_inc     = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mrpt_pkg::MUL_X_X;
                    n_state         = S_SQ_MUL;
                end
            end
            S_SQ_MUL: begin
                if (!i_stat.mul_busy) begin
                    n_state = S_SQ_CHK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prime <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prime <= n_prime;
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_DONE);
    assign o_is_prime = r_prime;

    `MRPT_ASSERT(a_start_takes, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy, "accepted item did not raise busy")
    `MRPT_ASSERT(a_valid_frees, i_clk, i_rst_n, o_valid |=> (!o_valid && !o_busy), "result strobe not followed by idle")
    `MRPT_ASSERT(a_mul_free, i_clk, i_rst_n, o_cmd.mul_start |-> !i_stat.mul_busy, "multiply started while multiplier busy")
    `MRPT_ASSERT(a_mul_wait, i_clk, i_rst_n, o_cmd.mul_start |=> i_stat.mul_busy, "multiplier did not take the start")

endmodule

`default_nettype wire

### rtl/miller_rabin_prime_test_core.sv
// Top level of the deterministic 64-bit Miller-Rabin prime test core.
//
//  Channel | Ports                   | Handshake
//  --------+-------------------------+--------------------------------------------
//  input   | i_candidate             | item taken at edge with start high, busy low
//  result  | o_is_prime              | o_valid high one cycle, taken at its end
//
// One item at a time. On the short paths (below two, even, two) the check state goes
// straight to the done state, which raises the strobe. A full test runs the d/s split,
// then up to 12 witnesses, each a square-and-multiply ladder plus squaring chain; every
// modular product goes through the bit-serial shift-and-add multiplier at one
// multiplier bit per cycle. Reset (synchronous, active low) returns the controller to
// idle; busy drops. The receiver cannot stall: the result strobe lasts exactly one cycle.
`default_nettype none

module miller_rabin_prime_test_core #(
    parameter int WIDTH = mrpt_pkg::DEFAULT_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_candidate,
    output logic             o_valid,
    output logic             o_is_prime
);

    mrpt_pkg::t_cmd  cmd;
    mrpt_pkg::t_stat stat;

    // Sequencer: owns the state, the busy flag and the result bit.
    mrpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    // Arithmetic: masks the candidate to WIDTH bits and holds all operands.
    mrpt_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

### test/miller_rabin_prime_test_core_tb.sv
// Testbench for the Miller-Rabin prime test core: directed and random candidates.
`default_nettype none

module miller_rabin_prime_test_core_tb;

    // Match the core's default width so that candidate masking agrees with it
    localparam int CAND_WIDTH    = mrpt_pkg::DEFAULT_WIDTH;
    localparam int RANDOM_ITEMS  = 77;
    localparam int SETTLE_CYCLES = 200;

    // Known corner cases: smallest values, the two-and-even reject paths,
    // witnesses at or above the candidate, classic strong pseudoprimes,
    // large primes near the top of the range and the all-ones word
    localparam logic [63:0] DIRECTED_SET [23] = '{
        64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd31, 64'd37, 64'd41,
        64'd561, 64'd2047, 64'd65537, 64'd1373653, 64'd25326001,
        64'd3215031751, 64'd4294967311, 64'd2305843009213693951,
        64'd3825123056546413051, 64'd9223372036854775808,
        64'd9223372036854775809, 64'd18446744073709551557,
        64'd18446744073709551614, 64'd18446744073709551615
    };

    class prime_scoreboard;
        typedef struct {
            logic [63:0] candidate;
            logic        is_prime;
        } verdict_t;

        // Fixed witnesses 2..37, six bits each, lowest first
        localparam logic [71:0] WITNESS_SET = {
            6'd37, 6'd31, 6'd29, 6'd23, 6'd19, 6'd17,
            6'd13, 6'd11, 6'd7, 6'd5, 6'd3, 6'd2
        };

        verdict_t    pending_verdicts[$];
        logic [63:0] cand_mask;
        int unsigned n_fail;
        int unsigned n_seen;
        int unsigned n_primes;

        function new(int width);
            cand_mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
            n_fail    = 0;
            n_seen    = 0;
            n_primes  = 0;
        endfunction

        function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
            logic [127:0] prod;
            prod = ({64'd0, a} * {64'd0, b}) % {64'd0, m};
            return prod[63:0];
        endfunction

        function logic prime_verdict(logic [63:0] raw);
            logic [63:0] n;
            logic [63:0] nm1;
            logic [63:0] d;
            logic [63:0] x;
            logic [63:0] base;
            logic [63:0] e;
            int unsigned s;
            bit          composite;
            n = raw & cand_mask;
            if (n == 64'd2) return 1'b1;
            if (n < 64'd2 || !n[0]) return 1'b0;
            nm1 = n - 64'd1;
            d   = nm1;
            s   = 0;
            while (!d[0]) begin
                d = d >> 1;
                s++;
            end
            for (int k = 0; k < 12; k++) begin
                base = {58'd0, WITNESS_SET[6*k +: 6]};
                if (base >= n) continue;
                x = 64'd1;
                e = d;
                while (e != 64'd0) begin
                    if (e[0]) x = mul_mod(x, base, n);
                    base = mul_mod(base, base, n);
                    e = e >> 1;
                end
                if (x == 64'd1 || x == nm1) continue;
                composite = 1'b1;
                for (int unsigned r = 1; r < s; r++) begin
                    x = mul_mod(x, x, n);
                    if (x == nm1) begin
                        composite = 1'b0;
                        break;
                    end
                    if (x == 64'd1) break;
                end
                if (composite) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_candidate(logic [63:0] value);
            verdict_t v;
            v.candidate = value;
            v.is_prime  = prime_verdict(value);
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        task report_mismatch(string what, logic [63:0] cand, logic want, logic got);
            $display("MISMATCH %s: candidate %0d expected is_prime=%0b got %0b",
                     what, cand, want, got);
            n_fail++;
        endtask

        task check_verdict(logic got);
            verdict_t v;
            n_seen++;
            if (got === 1'b1) n_primes++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no candidate waiting", 64'd0, 1'bx, got);
                return;
            end
            v = pending_verdicts.pop_front();
            if (got !== v.is_prime) begin
                report_mismatch("is_prime", v.candidate, v.is_prime, got);
            end
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [63:0] i_candidate = 64'd0;
    logic        busy;
    logic        o_valid;
    logic        o_is_prime;

    prime_scoreboard sb;

    miller_rabin_prime_test_core #(
        .WIDTH(CAND_WIDTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_candidate(i_candidate),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop, sized for every item taking the slowest path several times over
    initial begin
        #1_000_000_000;
        $display("miller_rabin_prime_test_core test failed");
        $finish;
    end

    // Take each result at the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            sb.check_verdict(o_is_prime);
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 88) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Keep most candidates narrow so full tests stay cheap; a few span all 64 bits
    function automatic logic [63:0] random_candidate();
        logic [63:0] v;
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 9);
        v    = {$urandom, $urandom};
        if (pick <= 6) begin
            len = $urandom_range(2, 20);
            v   = (v & ((64'd1 << len) - 64'd1)) | 64'd1;
        end else if (pick == 7) begin
            v[0] = 1'b1;
        end else if (pick == 9) begin
            v = 64'($urandom_range(0, 40));
        end
        return v;
    endfunction

    // Present one candidate and hold it until the core takes it. Leave start high
    // on return so that a back-to-back item needs no second assignment.
    task automatic send_candidate(input logic [63:0] value, input int unsigned gap);
        if (gap != 0) begin
            start       <= 1'b0;
            i_candidate <= {$urandom, $urandom};
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_candidate <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_candidate(value);
    endtask

    // Drop start and hold off until every outstanding verdict has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        bit burst;
        sb    = new(CAND_WIDTH);
        burst = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_SET[k]) begin
            send_candidate(DIRECTED_SET[k], pick_gap());
        end
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Every ten items, maybe run a stretch with no gaps at all
            if (i % 10 == 0) burst = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2) drain_results();
            send_candidate(random_candidate(), burst ? 0 : pick_gap());
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d verdicts over %0d directed and %0d random candidates",
                 sb.n_seen, $size(DIRECTED_SET), RANDOM_ITEMS);
        $display("Verdicts: %0d prime, %0d composite; %0d mismatches",
                 sb.n_primes, sb.n_seen - sb.n_primes, sb.n_fail);
        if (sb.n_fail == 0) begin
            $display("miller_rabin_prime_test_core test passed");
        end else begin
            $display("miller_rabin_prime_test_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
